FILE: rtl/core/rapc_pkg.sv
// Shared types and constants of the relay axis position controller.
package rapc_pkg;

    localparam int CMD_W   = 3;
    localparam int FIELD_W = 23;
    localparam int ANGLE_W = 32;
    localparam int QUOT_W  = 22;
    localparam int MODE_W  = 3;

    // Command codes of the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_EDGE    = 3'd1,
        CMD_MOVE_TO = 3'd2,
        CMD_RUN_POS = 3'd3,
        CMD_RUN_NEG = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_SET_POS = 3'd6
    } cmd_t;

    // Motor state codes as they appear on the result channel.
    localparam logic [MODE_W-1:0] MOTOR_STOPPED   = 3'd0;
    localparam logic [MODE_W-1:0] MOTOR_RUN_POS   = 3'd1;
    localparam logic [MODE_W-1:0] MOTOR_RUN_NEG   = 3'd2;
    localparam logic [MODE_W-1:0] MOTOR_COAST_POS = 3'd3;
    localparam logic [MODE_W-1:0] MOTOR_COAST_NEG = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEAD_TIME  = 2'd0;
    localparam logic [1:0] CFG_ANGLE_STEP = 2'd1;
    localparam logic [1:0] CFG_HYSTERESIS = 2'd2;
    localparam logic [1:0] CFG_STOP_TIME  = 2'd3;

    typedef struct packed {
        logic [7:0]  dead_time_ms;
        logic [15:0] angle_per_count;
        logic [19:0] hysteresis;
        logic [15:0] stop_time_ms;
    } cfg_t;

    localparam logic [7:0]  DEAD_TIME_RST  = 8'd2;
    localparam logic [15:0] ANGLE_STEP_RST = 16'd375;
    localparam logic [19:0] HYSTERESIS_RST = 20'd5000;
    localparam logic [15:0] STOP_TIME_RST  = 16'd500;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pos_relay;
        logic              neg_relay;
        logic              stopped;
    } status_t;

    // floor(x / 1000) = (x * ceil(2^41 / 1000)) >> 41, exact for x up to 2^31.
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    localparam int          DIV_SHIFT  = 41;

endpackage

FILE: rtl/core/rapc_update.sv
// Axis state, relay state machine and per-command state update.
module rapc_update #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step,
    input  logic [rapc_pkg::CMD_W-1:0]            cmd,
    input  logic signed [rapc_pkg::FIELD_W-1:0]   value,
    input  rapc_pkg::cfg_t                        cfg,
    output rapc_pkg::status_t                     status,
    output logic signed [rapc_pkg::ANGLE_W-1:0]   actual,
    output logic signed [rapc_pkg::ANGLE_W-1:0]   target
);
    import rapc_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        ST_STOPPED   = MOTOR_STOPPED,
        ST_RUN_POS   = MOTOR_RUN_POS,
        ST_RUN_NEG   = MOTOR_RUN_NEG,
        ST_COAST_POS = MOTOR_COAST_POS,
        ST_COAST_NEG = MOTOR_COAST_NEG
    } mode_t;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    // Tenths of a degree to 1e-4 degree, saturated to the 32-bit range.
    function automatic logic signed [ANGLE_W-1:0] scale_sat(
        input logic signed [FIELD_W-1:0] v
    );
        logic signed [33:0] w;
        logic signed [33:0] p;
        logic signed [ANGLE_W-1:0] r;
        w = {{(34 - FIELD_W){v[FIELD_W-1]}}, v};
        p = (w <<< 10) - (w <<< 4) - (w <<< 3);
        if (p > SAT_HI) begin
            r = SAT_HI[ANGLE_W-1:0];
        end else if (p < SAT_LO) begin
            r = SAT_LO[ANGLE_W-1:0];
        end else begin
            r = p[ANGLE_W-1:0];
        end
        return r;
    endfunction

    logic [TIME_WIDTH-1:0] time_now_reg, time_now_next;
    logic [TIME_WIDTH-1:0] last_edge_reg, last_edge_next;
    logic [TIME_WIDTH-1:0] due_reg, due_next;
    logic signed [ANGLE_W-1:0] actual_reg, actual_next;
    logic signed [ANGLE_W-1:0] target_reg, target_next;
    mode_t mode_reg, mode_next;
    mode_t pending_reg, pending_next;
    logic stop_at_target_reg, stop_at_target_next;

    logic [TIME_WIDTH-1:0] time_tick;
    logic [TIME_WIDTH-1:0] tt;
    logic [TIME_WIDTH-1:0] dead_ext;
    logic [TIME_WIDTH-1:0] stop_ext;
    logic                  stalled;
    logic                  req_en;
    mode_t                 req_mode;
    logic                  enter;
    logic signed [ANGLE_W-1:0] scaled;
    logic signed [33:0]    tgt_w;
    logic signed [33:0]    act_w;
    logic signed [33:0]    hyst_w;

    always_comb begin
        time_now_next       = time_now_reg;
        last_edge_next      = last_edge_reg;
        due_next            = due_reg;
        actual_next         = actual_reg;
        target_next         = target_reg;
        mode_next           = mode_reg;
        pending_next        = pending_reg;
        stop_at_target_next = stop_at_target_reg;

        time_tick = time_now_reg + 1'b1;
        tt        = (cmd == CMD_TICK) ? time_tick : time_now_reg;
        dead_ext  = TIME_WIDTH'(cfg.dead_time_ms);
        stop_ext  = TIME_WIDTH'(cfg.stop_time_ms);
        stalled   = time_tick > (last_edge_reg + stop_ext);
        scaled    = scale_sat(value);
        tgt_w     = {{2{scaled[ANGLE_W-1]}}, scaled};
        act_w     = {{2{actual_reg[ANGLE_W-1]}}, actual_reg};
        hyst_w    = {14'b0, cfg.hysteresis};
        req_en    = 1'b0;
        req_mode  = ST_STOPPED;
        enter     = 1'b0;

        if (step) begin
            unique case (cmd)
                CMD_TICK: begin
                    time_now_next = time_tick;
                    unique case (mode_reg)
                        ST_RUN_POS: begin
                            req_en = stalled || (stop_at_target_reg && actual_reg >= target_reg);
                        end
                        ST_RUN_NEG: begin
                            req_en = stalled || (stop_at_target_reg && actual_reg <= target_reg);
                        end
                        ST_COAST_POS, ST_COAST_NEG: begin
                            req_en   = 1'b1;
                            req_mode = pending_reg;
                        end
                        default: begin
                            req_en = 1'b0;
                        end
                    endcase
                end
                CMD_EDGE: begin
                    if (time_now_reg > (last_edge_reg + dead_ext)) begin
                        last_edge_next = time_now_reg;
                        if (mode_reg == ST_RUN_POS || mode_reg == ST_COAST_POS) begin
                            actual_next = actual_reg + $signed({16'b0, cfg.angle_per_count});
                        end else if (mode_reg == ST_RUN_NEG || mode_reg == ST_COAST_NEG) begin
                            actual_next = actual_reg - $signed({16'b0, cfg.angle_per_count});
                        end
                    end
                end
                CMD_MOVE_TO: begin
                    stop_at_target_next = 1'b1;
                    target_next         = scaled;
                    req_en              = 1'b1;
                    if (tgt_w > act_w + hyst_w) begin
                        req_mode = ST_RUN_POS;
                    end else if (tgt_w < act_w - hyst_w) begin
                        req_mode = ST_RUN_NEG;
                    end
                end
                CMD_RUN_POS: begin
                    stop_at_target_next = 1'b0;
                    req_en              = 1'b1;
                    req_mode            = ST_RUN_POS;
                end
                CMD_RUN_NEG: begin
                    stop_at_target_next = 1'b0;
                    req_en              = 1'b1;
                    req_mode            = ST_RUN_NEG;
                end
                CMD_STOP: begin
                    stop_at_target_next = 1'b1;
                    req_en              = 1'b1;
                end
                CMD_SET_POS: begin
                    actual_next = scaled;
                end
                default: begin
                    req_en = 1'b0;
                end
            endcase
        end

        // A stop or reversal from a running state always passes through coasting.
        if (req_en) begin
            unique case (mode_reg)
                ST_RUN_POS: begin
                    if (req_mode == ST_RUN_NEG || req_mode == ST_STOPPED) begin
                        mode_next    = ST_COAST_POS;
                        due_next     = tt + stop_ext;
                        pending_next = req_mode;
                    end
                end
                ST_RUN_NEG: begin
                    if (req_mode == ST_RUN_POS || req_mode == ST_STOPPED) begin
                        mode_next    = ST_COAST_NEG;
                        due_next     = tt + stop_ext;
                        pending_next = req_mode;
                    end
                end
                ST_COAST_POS, ST_COAST_NEG: begin
                    enter = (req_mode == ST_STOPPED || req_mode == ST_RUN_POS ||
                             req_mode == ST_RUN_NEG) && (tt > due_reg);
                end
                default: begin
                    enter = (req_mode == ST_RUN_POS || req_mode == ST_RUN_NEG);
                end
            endcase
        end

        if (enter) begin
            mode_next = req_mode;
            // Starting to run skips the dead time: an edge counts from the next tick on.
            if (req_mode == ST_RUN_POS || req_mode == ST_RUN_NEG) begin
                last_edge_next = tt - dead_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg       <= '0;
            last_edge_reg      <= '0;
            due_reg            <= '0;
            actual_reg         <= '0;
            target_reg         <= '0;
            mode_reg           <= ST_STOPPED;
            pending_reg        <= ST_STOPPED;
            stop_at_target_reg <= 1'b1;
        end else begin
            time_now_reg       <= time_now_next;
            last_edge_reg      <= last_edge_next;
            due_reg            <= due_next;
            actual_reg         <= actual_next;
            target_reg         <= target_next;
            mode_reg           <= mode_next;
            pending_reg        <= pending_next;
            stop_at_target_reg <= stop_at_target_next;
        end
    end

    always_comb begin
        status.mode      = mode_next;
        status.pos_relay = (mode_next == ST_RUN_POS);
        status.neg_relay = (mode_next == ST_RUN_NEG);
        status.stopped   = (mode_next == ST_STOPPED);
    end

    assign actual = actual_next;
    assign target = target_next;

endmodule

FILE: rtl/core/rapc_div1000.sv
// Registered division of a magnitude by 1000 through a reciprocal multiply.
module rapc_div1000 (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [rapc_pkg::ANGLE_W-1:0] mag,
    output logic [rapc_pkg::QUOT_W-1:0]  quot_reg
);
    import rapc_pkg::*;

    logic [2*ANGLE_W-1:0] product;

    assign product = (2*ANGLE_W)'(mag) * (2*ANGLE_W)'(RECIP_1000);

    always_ff @(posedge aclk) begin
        if (load) begin
            quot_reg <= product[DIV_SHIFT +: QUOT_W];
        end
    end

endmodule

FILE: rtl/core/relay_axis_position_controller.sv
// Relay axis position controller: input register, state update, scaling and output stages.
//
// Usage: each transfer on the s_ channel carries one command (tick, encoder edge, move to,
// run positive, run negative, stop, set position) and a value in 0.1 degree. Every command
// produces exactly one transfer on the m_ channel that reports the motor state, both relay
// drives, and the current position and setpoint in 0.1 degree after that command.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and writes are expected only while no command is in flight.
// A command passes the input, update, multiply and output registers to m_valid. One command
// is taken every cycle unless the receiver stalls: the state update has a stage of its own,
// and the divide by 1000 for the reported angles is a reciprocal multiply in the next stage.
// When the receiver stalls, the four stages fill up and s_ready falls; nothing is lost.
// Reset (aresetn low, synchronous) empties the pipeline, stops the motor with both relays
// off, clears time and angles and loads the default configuration.
module relay_axis_position_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rapc_pkg::CMD_W-1:0]            s_cmd,
    input  logic signed [rapc_pkg::FIELD_W-1:0]   s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [rapc_pkg::MODE_W-1:0]           m_motor_state,
    output logic                                  m_pos_relay,
    output logic                                  m_neg_relay,
    output logic signed [rapc_pkg::FIELD_W-1:0]   m_position_tenths,
    output logic signed [rapc_pkg::FIELD_W-1:0]   m_setpoint_tenths,
    output logic                                  m_at_rest,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [31:0]                           cfg_data
);
    import rapc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic in_valid_reg, in_valid_next;
    logic upd_valid_reg, upd_valid_next;
    logic mul_valid_reg, mul_valid_next;
    logic m_valid_reg, m_valid_next;

    logic [CMD_W-1:0]          cmd_reg;
    logic signed [FIELD_W-1:0] value_reg;

    status_t                   upd_status;
    logic signed [ANGLE_W-1:0] upd_actual;
    logic signed [ANGLE_W-1:0] upd_target;

    status_t                   upd_status_reg;
    logic [ANGLE_W-1:0]        act_mag_reg;
    logic                      act_neg_reg;
    logic [ANGLE_W-1:0]        tgt_mag_reg;
    logic                      tgt_neg_reg;

    status_t                   mul_status_reg;
    logic                      mul_act_neg_reg;
    logic                      mul_tgt_neg_reg;
    logic [QUOT_W-1:0]         act_quot_reg;
    logic [QUOT_W-1:0]         tgt_quot_reg;

    status_t                   out_status_reg;
    logic signed [FIELD_W-1:0] position_reg;
    logic signed [FIELD_W-1:0] setpoint_reg;

    logic out_ready;
    logic mul_ready;
    logic upd_ready;
    logic in_load;
    logic upd_load;
    logic mul_load;
    logic out_load;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEAD_TIME:  cfg_next.dead_time_ms    = cfg_data[7:0];
                CFG_ANGLE_STEP: cfg_next.angle_per_count = cfg_data[15:0];
                CFG_HYSTERESIS: cfg_next.hysteresis      = cfg_data[19:0];
                CFG_STOP_TIME:  cfg_next.stop_time_ms    = cfg_data[15:0];
            endcase
        end
    end

    // Pipeline flow: a stage takes a new transfer when it is empty or moving on.
    assign out_ready = !m_valid_reg || m_ready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign upd_ready = !upd_valid_reg || mul_ready;
    assign s_ready   = !in_valid_reg || upd_ready;

    assign in_load  = s_valid && s_ready;
    assign upd_load = in_valid_reg && upd_ready;
    assign mul_load = upd_valid_reg && mul_ready;
    assign out_load = mul_valid_reg && out_ready;

    assign in_valid_next  = in_load || (in_valid_reg && !upd_ready);
    assign upd_valid_next = upd_load || (upd_valid_reg && !mul_ready);
    assign mul_valid_next = mul_load || (mul_valid_reg && !out_ready);
    assign m_valid_next   = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_time_ms    <= DEAD_TIME_RST;
            cfg_reg.angle_per_count <= ANGLE_STEP_RST;
            cfg_reg.hysteresis      <= HYSTERESIS_RST;
            cfg_reg.stop_time_ms    <= STOP_TIME_RST;
            in_valid_reg            <= 1'b0;
            upd_valid_reg           <= 1'b0;
            mul_valid_reg           <= 1'b0;
            m_valid_reg             <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            upd_valid_reg <= upd_valid_next;
            mul_valid_reg <= mul_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            cmd_reg   <= s_cmd;
            value_reg <= s_value;
        end
    end

    // The state advances exactly once per command, when it leaves the input register.
    rapc_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (upd_load),
        .cmd     (cmd_reg),
        .value   (value_reg),
        .cfg     (cfg_reg),
        .status  (upd_status),
        .actual  (upd_actual),
        .target  (upd_target)
    );

    always_ff @(posedge aclk) begin
        if (upd_load) begin
            upd_status_reg <= upd_status;
            act_neg_reg    <= upd_actual[ANGLE_W-1];
            tgt_neg_reg    <= upd_target[ANGLE_W-1];
            act_mag_reg    <= upd_actual[ANGLE_W-1] ? ANGLE_W'(-upd_actual) : upd_actual;
            tgt_mag_reg    <= upd_target[ANGLE_W-1] ? ANGLE_W'(-upd_target) : upd_target;
        end
    end

    rapc_div1000 u_div_actual (
        .aclk     (aclk),
        .load     (mul_load),
        .mag      (act_mag_reg),
        .quot_reg (act_quot_reg)
    );

    rapc_div1000 u_div_target (
        .aclk     (aclk),
        .load     (mul_load),
        .mag      (tgt_mag_reg),
        .quot_reg (tgt_quot_reg)
    );

    always_ff @(posedge aclk) begin
        if (mul_load) begin
            mul_status_reg  <= upd_status_reg;
            mul_act_neg_reg <= act_neg_reg;
            mul_tgt_neg_reg <= tgt_neg_reg;
        end
    end

    // Quotients of magnitudes get their sign back, which truncates toward zero.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= mul_status_reg;
            position_reg   <= mul_act_neg_reg ? -$signed({1'b0, act_quot_reg})
                                              : $signed({1'b0, act_quot_reg});
            setpoint_reg   <= mul_tgt_neg_reg ? -$signed({1'b0, tgt_quot_reg})
                                              : $signed({1'b0, tgt_quot_reg});
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_motor_state     = out_status_reg.mode;
    assign m_pos_relay       = out_status_reg.pos_relay;
    assign m_neg_relay       = out_status_reg.neg_relay;
    assign m_at_rest         = out_status_reg.stopped;
    assign m_position_tenths = position_reg;
    assign m_setpoint_tenths = setpoint_reg;

endmodule

FILE: rtl/core/rapc_checker.sv
// Port-level checks of the relay axis position controller and their binding.
module rapc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rapc_pkg::MODE_W-1:0]         m_motor_state,
    input logic                                m_pos_relay,
    input logic                                m_neg_relay,
    input logic signed [rapc_pkg::FIELD_W-1:0] m_position_tenths,
    input logic signed [rapc_pkg::FIELD_W-1:0] m_setpoint_tenths,
    input logic                                m_at_rest
);
    import rapc_pkg::*;

    // Both relays on at once would short the motor supply.
    a_relays_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_pos_relay && m_neg_relay))
        else $error("both relays driven");

    // A relay is on only in the matching running state.
    a_relays_match_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pos_relay == (m_motor_state == MOTOR_RUN_POS)) &&
                    (m_neg_relay == (m_motor_state == MOTOR_RUN_NEG)))
        else $error("relay drive does not match motor state");

    a_stopped_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_at_rest == (m_motor_state == MOTOR_STOPPED)))
        else $error("stopped flag does not match motor state");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_motor_state) &&
            $stable(m_position_tenths) && $stable(m_setpoint_tenths))
        else $error("stalled result transfer changed");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind relay_axis_position_controller rapc_checker u_rapc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_motor_state     (m_motor_state),
    .m_pos_relay       (m_pos_relay),
    .m_neg_relay       (m_neg_relay),
    .m_position_tenths (m_position_tenths),
    .m_setpoint_tenths (m_setpoint_tenths),
    .m_at_rest         (m_at_rest)
);
